>>> design/hecr_pkg.sv
// Package for the histogram equalized color ramp unit.
// Holds field structs, request codes, sizes and register indexes; no dependencies.
package hecr_pkg;

  localparam int MAX_ITER_DEF   = 1024;
  localparam int NUM_RANGES_DEF = 4;
  localparam int MAX_PIXELS_DEF = 1048576;

  localparam int IT_W   = 11;
  localparam int CNT_W  = 21;
  localparam int COL_W  = 24;
  localparam int ADDR_W = 5;
  localparam int SUM_W  = 32;
  // Dividend width: a bin sum times a channel difference of up to 255.
  localparam int NUM_W  = SUM_W + 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_ACCUM  = 2'd1;
  localparam logic [1:0] REQ_COLOR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] REG_START0 = 3'd0;
  localparam logic [2:0] REG_COLOR0 = 3'd4;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [IT_W-1:0] iterations;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item
    logic clr_step;  // clear one bin, advance the pointer
    logic clr_tot;   // clear range totals
    logic rd_bin;    // issue histogram read at the count, range start or pointer
    logic acc_wr;    // write the incremented bin and total
    logic sum_add;   // add read bin into the sum, advance pointer
    logic div_init;  // start the channel divisions
    logic div_step;  // one quotient bit
    logic black;     // result is black
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic walk_last;
    logic walk_empty;
    logic div_last;
    logic at_limit;
    logic [1:0] req;
  } stat_t;

endpackage

>>> design/hecr_ctrl.sv
// Controller state machine of the color ramp unit.
// Depends on hecr_pkg for command and status structs.
module hecr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output hecr_pkg::cmd_t cmd,
  input  hecr_pkg::stat_t st
);
  import hecr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_ACRD = 3'd7;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       walk_started, walk_started_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next        = state;
    out_valid_next    = out_valid;
    walk_started_next = walk_started;
    cmd = '0;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        priority if (st.req == REQ_CLEAR) begin
          cmd.clr_tot = 1'b1;
          state_next  = S_CLR;
        end else if (st.req == REQ_ACCUM && !st.at_limit) begin
          cmd.rd_bin = 1'b1;
          state_next = S_ACRD;
        end else if (st.req == REQ_COLOR && st.at_limit) begin
          cmd.black  = 1'b1;
          state_next = S_OUT;
        end else if (st.req == REQ_COLOR) begin
          walk_started_next = 1'b0;
          state_next = S_WALK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_ACRD: state_next = S_ACC;
      S_ACC: begin
        cmd.acc_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_WALK: begin
        // Bin read issued, added from the read register the next cycle; pointer moves on each add.
        if (!walk_started) begin
          if (st.walk_empty) begin
            cmd.div_init = 1'b1;
            state_next   = S_DIV;
          end else begin
            cmd.rd_bin        = 1'b1;
            walk_started_next = 1'b1;
          end
        end else begin
          cmd.sum_add = 1'b1;
          if (st.walk_last) begin
            state_next = S_DIV;
          end else begin
            cmd.rd_bin = 1'b1;
          end
        end
        if (walk_started && st.walk_last) walk_started_next = 1'b0;
      end
      S_DIV: begin
        if (walk_started == 1'b0 && !cmd.div_init) begin
          cmd.div_init      = 1'b1;
          walk_started_next = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
          if (st.div_last) state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      out_valid    <= 1'b0;
      walk_started <= 1'b0;
    end else begin
      state        <= state_next;
      out_valid    <= out_valid_next;
      walk_started <= walk_started_next;
    end
  end

endmodule

>>> design/hecr_dp.sv
// Datapath of the color ramp unit: registers, histogram memory, sum and divider.
// Depends on hecr_pkg.
module hecr_dp #(
  parameter int MAX_ITER   = hecr_pkg::MAX_ITER_DEF,
  parameter int NUM_RANGES = hecr_pkg::NUM_RANGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hecr_pkg::in_item_t  in_item,
  output hecr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         cfg_rdata,
  input  hecr_pkg::cmd_t      cmd,
  output hecr_pkg::stat_t     st
);
  import hecr_pkg::*;

  localparam int HA_W = $clog2(MAX_ITER);
  localparam int DIV_STEPS = NUM_W;

  logic [IT_W-1:0]  bound [4];
  logic [COL_W-1:0] color [4];
  logic [CNT_W-1:0] hist [MAX_ITER];
  logic [CNT_W-1:0] tot [3];

  logic [1:0]       req;
  logic [IT_W-1:0]  it;
  logic [1:0]       rng;
  logic [HA_W:0]    ptr;
  logic [CNT_W-1:0] rd_data;
  logic [HA_W-1:0]  rd_addr;
  logic [SUM_W-1:0] sum;
  logic [5:0]       dcnt;
  logic             black;
  logic [7:0]       res [3];

  // Range lookup on the captured count.
  function automatic logic [1:0] find_range(input logic [IT_W-1:0] v,
                                            input logic [IT_W-1:0] b1,
                                            input logic [IT_W-1:0] b2,
                                            input logic [IT_W-1:0] b3);
    logic [1:0] r;
    logic       stop;
    r = 2'd0;
    stop = 1'b0;
    if (NUM_RANGES > 1) begin
      if (b1 > v) stop = 1'b1; else r = 2'd1;
    end
    if (NUM_RANGES > 2 && !stop) begin
      if (b2 > v) stop = 1'b1; else r = 2'd2;
    end
    if (NUM_RANGES > 3 && !stop) begin
      if (b3 <= v) r = 2'd3;
    end
    if (r > 2'(NUM_RANGES - 2)) r = 2'(NUM_RANGES - 2);
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound[0] <= 11'd0;    bound[1] <= 11'd307;
      bound[2] <= 11'd512;  bound[3] <= 11'd1024;
      color[0] <= 24'd0;        color[1] <= 24'd16711680;
      color[2] <= 24'd16776960; color[3] <= 24'd16777215;
    end else if (cfg_we) begin
      if (cfg_idx < REG_COLOR0) bound[cfg_idx[1:0]] <= cfg_data[IT_W-1:0];
      else color[cfg_idx[1:0]] <= cfg_data[COL_W-1:0];
    end
  end

  always_comb begin
    if (cfg_idx < REG_COLOR0) cfg_rdata = {21'd0, bound[cfg_idx[1:0]]};
    else cfg_rdata = {8'd0, color[cfg_idx[1:0]]};
  end

  // Item capture and range.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_item.req_type;
      it  <= in_item.iterations;
      rng <= find_range(in_item.iterations, bound[1], bound[2], bound[3]);
    end
  end

  logic [IT_W-1:0] rstart;
  assign rstart = bound[rng];

  // Walk pointer: clearing sweep or bin walk from the range start.
  always_ff @(posedge clk) begin
    if (rst) ptr <= '0;
    else if (cmd.load) ptr <= '0;
    else if (cmd.clr_step) ptr <= ptr + 1'b1;
    else if (cmd.sum_add) ptr <= ptr + 1'b1;
    else if (cmd.rd_bin && req == REQ_COLOR && ptr == '0 && sum == '0 && dcnt == '0)
      ptr <= (HA_W+1)'(rstart) + 1'b1;
  end

  // Read address: the count for an accumulate; for a walk the range start, then the pointer.
  logic first_rd;
  assign first_rd = cmd.rd_bin && !cmd.sum_add;
  always_comb begin
    if (req == REQ_ACCUM) rd_addr = it[HA_W-1:0];
    else if (first_rd) rd_addr = rstart[HA_W-1:0];
    else rd_addr = ptr[HA_W-1:0];
  end

  // Histogram memory, one port each way, registered read.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) hist[ptr[HA_W-1:0]] <= '0;
    else if (cmd.acc_wr)
      hist[it[HA_W-1:0]] <= (rd_data == CNT_MAX) ? CNT_MAX : rd_data + 1'b1;
    if (cmd.rd_bin) rd_data <= hist[rd_addr];
  end

  // Range totals.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_tot) begin
      tot[0] <= '0; tot[1] <= '0; tot[2] <= '0;
    end else if (cmd.acc_wr && tot[rng] != CNT_MAX) begin
      tot[rng] <= tot[rng] + 1'b1;
    end
  end

  // Bin sum.
  always_ff @(posedge clk) begin
    if (cmd.load) sum <= '0;
    else if (cmd.sum_add) sum <= sum + SUM_W'(rd_data);
  end

  // Channel division, one quotient bit a cycle per channel.
  logic [CNT_W-1:0] total;
  assign total = tot[rng];
  always_ff @(posedge clk) begin
    if (cmd.load) dcnt <= '0;
    else if (cmd.div_init) dcnt <= '0;
    else if (cmd.div_step) dcnt <= dcnt + 1'b1;
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [7:0]       s8, e8;
    logic [8:0]       d9;
    logic [8:0]       mag;
    logic [CNT_W:0]   trial;
    logic [9:0]       v;
    logic [8:0]       q9;
    // Divider state: |diff*sum| / total, restoring.
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    logic [CNT_W:0]   rem;
    logic             neg;
    assign s8  = color[rng][23-8*c -: 8];
    assign e8  = color[rng+2'd1][23-8*c -: 8];
    assign d9  = {1'b0, e8} - {1'b0, s8};
    assign mag = d9[8] ? 9'(-d9) : d9;
    assign trial = {rem[CNT_W-1:0], num[NUM_W-1]};
    always_ff @(posedge clk) begin
      if (cmd.div_init) begin
        num <= NUM_W'(mag) * NUM_W'(sum);
        neg <= d9[8];
        quo <= '0;
        rem <= '0;
      end else if (cmd.div_step) begin
        num <= num << 1;
        if (trial >= {1'b0, total}) begin
          rem <= trial - {1'b0, total};
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
      end
    end
    // Apply sign and saturate.
    assign q9 = (quo > NUM_W'(255)) ? 9'd256 : quo[8:0];
    assign v  = (total == '0) ? {2'b0, s8}
              : (neg ? {2'b0, s8} - {1'b0, q9} : {2'b0, s8} + {1'b0, q9});
    assign res[c] = v[9] ? 8'd0 : (v[8] ? 8'd255 : v[7:0]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.black) black <= 1'b1;
    else if (cmd.load) black <= 1'b0;
    if (cmd.out_load) begin
      out_item.red   <= black ? 8'd0 : res[0];
      out_item.green <= black ? 8'd0 : res[1];
      out_item.blue  <= black ? 8'd0 : res[2];
    end
  end

  assign st.clr_last   = (ptr == (HA_W+1)'(MAX_ITER - 1));
  assign st.walk_empty = ({1'b0, rstart} > {1'b0, it});
  assign st.walk_last  = (ptr > (HA_W+1)'(it));
  assign st.div_last   = (dcnt == 6'(DIV_STEPS - 1));
  assign st.at_limit   = ({1'b0, it} >= (IT_W+1)'(MAX_ITER));
  assign st.req        = req;

endmodule

>>> design/histogram_equalized_color_ramp_unit.sv
// Top level of the histogram equalized color ramp unit.
// Depends on hecr_pkg, hecr_ctrl and hecr_dp.
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | in_item (req_type, iterations)
//  out     | out_valid/out_ready| out_item (red, green, blue)
//  cfg     | APB write/read     | range bounds and colors
//
// One item at a time. Clear: a sweep over all MAX_ITER bins. Accumulate: decode, read
// of the bin, write of the incremented bin and range total. Color: walk start, a read and
// add per bin from the range start up to the count, bit serial division (setup and 40
// quotient bits), output load; an empty walk runs the setup twice, a count of MAX_ITER or
// more gives black with no walk. After reset a clearing pass runs before the first item.
// The output register holds a finished result while the next item starts.
module histogram_equalized_color_ramp_unit #(
  parameter int MAX_ITER   = hecr_pkg::MAX_ITER_DEF,
  parameter int NUM_RANGES = hecr_pkg::NUM_RANGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hecr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hecr_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [hecr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hecr_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  hecr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .st
  );

  hecr_dp #(.MAX_ITER(MAX_ITER), .NUM_RANGES(NUM_RANGES)) u_dp (
    .clk, .rst, .in_item, .out_item,
    .cfg_we, .cfg_idx(paddr[4:2]), .cfg_data(pwdata), .cfg_rdata(prdata),
    .cmd, .st
  );

endmodule

>>> design/hecr_checker.sv
// Port level checker for the color ramp unit, bound to the top level.
// Depends on hecr_pkg.
module hecr_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input hecr_pkg::out_item_t out_item,
  input logic                pready
);
  import hecr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready while an item is in work");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind histogram_equalized_color_ramp_unit hecr_checker u_hecr_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_item, .pready
);

>>> sim/tb_top.sv
// Testbench for the histogram equalized color ramp unit.
// Depends on hecr_pkg and histogram_equalized_color_ramp_unit; self-checking, no files read.
`timescale 1ns / 100ps

module tb_top;
  import hecr_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int N_RANDOM     = 560;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  histogram_equalized_color_ramp_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predictor state: bounds, colors, histogram and range totals.
  logic [IT_W-1:0]  bound_q [4];
  logic [COL_W-1:0] color_q [4];
  logic [CNT_W-1:0] bins_q [MAX_ITER_DEF];
  logic [CNT_W-1:0] totals_q [3];

  out_item_t colors_pending[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_out = 1'b0;
  bit sending_done = 1'b0;

  function automatic int range_of(logic [IT_W-1:0] it);
    int r;
    r = 0;
    for (int i = 1; i < NUM_RANGES_DEF; i++) begin
      if (bound_q[i] > it) break;
      r = i;
    end
    if (r > NUM_RANGES_DEF - 2) r = NUM_RANGES_DEF - 2;
    return r;
  endfunction

  function automatic logic [7:0] ramp_channel(logic [7:0] s, logic [7:0] e,
                                              longint sum, longint total);
    longint v;
    v = s;
    if (total != 0) v = longint'(s) + ((longint'(e) - longint'(s)) * sum) / total;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Applies one accepted item to the predictor; queues a color if one results.
  function automatic void predict_item(in_item_t it);
    int r;
    longint sum;
    out_item_t c;
    case (it.req_type)
      REQ_CLEAR: begin
        foreach (bins_q[i]) bins_q[i] = '0;
        foreach (totals_q[i]) totals_q[i] = '0;
      end
      REQ_ACCUM: begin
        if (it.iterations < MAX_ITER_DEF) begin
          if (bins_q[it.iterations] != CNT_MAX) bins_q[it.iterations]++;
          r = range_of(it.iterations);
          if (totals_q[r] != CNT_MAX) totals_q[r]++;
        end
      end
      REQ_COLOR: begin
        if (it.iterations >= MAX_ITER_DEF) begin
          c = '0;
        end else begin
          r = range_of(it.iterations);
          sum = 0;
          for (int i = bound_q[r]; i <= it.iterations; i++) sum += bins_q[i];
          c.red   = ramp_channel(color_q[r][23:16], color_q[r+1][23:16], sum, totals_q[r]);
          c.green = ramp_channel(color_q[r][15:8], color_q[r+1][15:8], sum, totals_q[r]);
          c.blue  = ramp_channel(color_q[r][7:0], color_q[r+1][7:0], sum, totals_q[r]);
        end
        colors_pending = {colors_pending, c};
      end
      default: ;
    endcase
  endfunction

  // Register write through the configuration port, mirrored in the predictor.
  task automatic write_reg(int idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = ADDR_W'(4 * idx); pwdata = val; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx < 4) bound_q[idx] = val[IT_W-1:0];
    else color_q[idx-4] = val[COL_W-1:0];
  endtask

  task automatic send_item(in_item_t it);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until all colors arrived, then lets the block settle.
  task automatic drain;
    while (colors_pending.size() != 0) @(posedge clk);
    repeat (MAX_ITER_DEF + 200) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] rq, logic [IT_W-1:0] it);
    in_item_t x;
    x.req_type = rq;
    x.iterations = it;
    return x;
  endfunction

  // Random item, mostly accumulates and colors with counts spread over the ranges.
  function automatic in_item_t rand_item();
    int p;
    logic [IT_W-1:0] it;
    p = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0: it = IT_W'($urandom_range(0, 2047));
      1: it = IT_W'($urandom_range(0, 15));
      2: it = IT_W'($urandom_range(1000, 1024));
      default: it = IT_W'($urandom_range(0, 1023));
    endcase
    if (p < 2) return mk(REQ_CLEAR, it);
    if (p < 4) return mk(REQ_UNUSED, it);
    if (p < 62) return mk(REQ_ACCUM, it);
    return mk(REQ_COLOR, it);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (colors_pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected color item %h", out_item);
      end else begin
        out_item_t e;
        e = colors_pending.pop_front();
        checked++;
        if (e.red !== out_item.red || e.green !== out_item.green || e.blue !== out_item.blue) begin
          errors++;
          if (errors <= 10) $display("color mismatch: expected %h actual %h", e, out_item);
        end
      end
    end
  end

  // Receiver: random stall bursts, or a long hold-off on request.
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 3000) begin
          @(negedge clk);
          hold++;
        end
        hold_out = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("histogram_equalized_color_ramp_unit: mismatch");
      $finish;
    end
  end

  typedef struct {
    in_item_t  it;
    bit        has_known;
    out_item_t known;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    bound_q = '{11'd0, 11'd307, 11'd512, 11'd1024};
    color_q = '{24'd0, 24'd16711680, 24'd16776960, 24'd16777215};
    foreach (bins_q[i]) bins_q[i] = '0;
    foreach (totals_q[i]) totals_q[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: empty-histogram colors are start colors, inside pixels black.
    row = '{mk(REQ_COLOR, 11'd0), 1'b1, 24'h000000};     rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd400), 1'b1, 24'hFF0000};   rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd1023), 1'b1, 24'hFFFF00};  rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd1024), 1'b1, 24'h000000};  rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd2047), 1'b1, 24'h000000};  rows = {rows, row};
    row = '{mk(REQ_UNUSED, 11'd5), 1'b0, '0};            rows = {rows, row};
    row = '{mk(REQ_ACCUM, 11'd0), 1'b0, '0};             rows = {rows, row};
    row = '{mk(REQ_ACCUM, 11'd306), 1'b0, '0};           rows = {rows, row};
    row = '{mk(REQ_ACCUM, 11'd307), 1'b0, '0};           rows = {rows, row};
    row = '{mk(REQ_ACCUM, 11'd1023), 1'b0, '0};          rows = {rows, row};
    row = '{mk(REQ_ACCUM, 11'd1024), 1'b0, '0};          rows = {rows, row};
    row = '{mk(REQ_ACCUM, 11'd2047), 1'b0, '0};          rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd0), 1'b0, '0};             rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd306), 1'b0, '0};           rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd307), 1'b0, '0};           rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd1023), 1'b0, '0};          rows = {rows, row};
    row = '{mk(REQ_CLEAR, 11'd0), 1'b0, '0};             rows = {rows, row};
    row = '{mk(REQ_COLOR, 11'd1023), 1'b1, 24'hFFFF00};  rows = {rows, row};
    foreach (rows[k]) begin
      send_item(rows[k].it);
      if (rows[k].has_known) begin
        if (colors_pending[$] !== rows[k].known) begin
          errors++;
          if (errors <= 10) $display("table row %0d: model %h table %h",
                                     k, colors_pending[$], rows[k].known);
        end
      end
    end
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(0, 0); write_reg(1, 1); write_reg(2, 2); write_reg(3, 1024);
          write_reg(4, 24'hFFFFFF); write_reg(5, 24'h000000);
          write_reg(6, 24'hFFFFFF); write_reg(7, 24'h000000);
        end
        2: begin
          // Bounds not increasing and first bound above zero.
          write_reg(0, 100); write_reg(1, 800); write_reg(2, 300); write_reg(3, 2047);
          for (int r = 0; r < 4; r++) write_reg(4 + r, $urandom_range(0, 24'hFFFFFF));
        end
        3: begin
          write_reg(0, 2047); write_reg(1, 0); write_reg(2, 1024); write_reg(3, 0);
          write_reg(4, 24'h123456); write_reg(5, 24'hFEDCBA);
          write_reg(6, 24'h00FF00); write_reg(7, 24'hFF00FF);
        end
        default: begin
          for (int r = 0; r < 4; r++) write_reg(r, $urandom_range(0, 1024));
          for (int r = 0; r < 4; r++) write_reg(4 + r, $urandom_range(0, 24'hFFFFFF));
        end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        if (ph == 1 && n == 20) hold_out = 1'b1;
        if (ph == 4 && n > 60) no_idle = 1'b1;
        send_item(rand_item());
      end
      drain();
    end

    $display("Covered %0d colors over table rows and five register settings,", checked);
    $display("with a long receiver hold-off and random idling.");
    if (errors == 0 && colors_pending.size() == 0) begin
      $display("histogram_equalized_color_ramp_unit: match");
    end else begin
      $display("histogram_equalized_color_ramp_unit: mismatch");
    end
    $finish;
  end

endmodule
